@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scale estimator RTL.
// Depends on nothing; each user supplies clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define OSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define OSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/osest_pkg.sv @@
// Shared types and constants of the odometry scale estimator.
// Used by osest_ctrl, osest_dp and the top level; depends on nothing.
package osest_pkg;

  localparam int DIST_W   = 24;
  localparam int SCALE_W  = 24;
  localparam int CNT_W    = 8;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = 32;
  localparam int STATUS_W = 3;

  // Shared shift-subtract divider
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SCALE = DIV_CNT_W'(SCALE_W);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MEAN  = DIV_CNT_W'(DIV_W);

  // Register port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_MIN_VISUAL    = 3'd0;
  localparam logic [2:0] REG_SCALE_LOW     = 3'd1;
  localparam logic [2:0] REG_SCALE_HIGH    = 3'd2;
  localparam logic [2:0] REG_INIT_COUNT    = 3'd3;
  localparam logic [2:0] REG_GATE_FRACTION = 3'd4;
  localparam logic [2:0] REG_EMA_ALPHA     = 3'd5;

  localparam logic [DIST_W-1:0]  MIN_VISUAL_RST    = 24'd66;
  localparam logic [SCALE_W-1:0] SCALE_LOW_RST     = 24'd655;
  localparam logic [SCALE_W-1:0] SCALE_HIGH_RST    = 24'd6553600;
  localparam logic [CNT_W-1:0]   INIT_COUNT_RST    = 8'd10;
  localparam logic [FRAC_W-1:0]  GATE_FRACTION_RST = 16'd32768;
  localparam logic [FRAC_W-1:0]  EMA_ALPHA_RST     = 16'd1311;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h010000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SMALL_VISUAL = 3'd0,
    ST_OUT_OF_RANGE = 3'd1,
    ST_ACCUMULATED  = 3'd2,
    ST_INITIALIZED  = 3'd3,
    ST_EMA_UPDATED  = 3'd4,
    ST_GATED        = 3'd5
  } status_t;

  typedef struct packed {
    logic [DIST_W-1:0]  min_visual;
    logic [SCALE_W-1:0] scale_low;
    logic [SCALE_W-1:0] scale_high;
    logic [CNT_W-1:0]   init_count;
    logic [FRAC_W-1:0]  gate_fraction;
    logic [FRAC_W-1:0]  ema_alpha;
  } cfg_t;

  typedef struct packed {
    logic    load_in;
    logic    load_sat;
    logic    div_start_scale;
    logic    div_start_mean;
    logic    div_step;
    logic    accumulate;
    logic    set_mean;
    logic    mul;
    logic    ema_apply;
    logic    out_load;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic vis_small;
    logic sat;
    logic out_of_range;
    logic init_done;
    logic count_reached;
    logic div_last;
    logic gate_pass;
  } sts_t;

endpackage

@@ rtl/osest_dp.sv @@
// Datapath of the scale estimator: operand latch, shared divider, EMA products,
// estimator state and result registers. Depends on osest_pkg and assert_macros.svh.
`include "assert_macros.svh"

module osest_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  osest_pkg::cfg_t                     cfg,
  input  osest_pkg::cmd_t                     cmd,
  output osest_pkg::sts_t                     sts,
  input  logic [osest_pkg::DIST_W-1:0]        odom_dist,
  input  logic [osest_pkg::DIST_W-1:0]        visual_dist,
  output logic [osest_pkg::SCALE_W-1:0]       scale_out,
  output logic                                is_initialized,
  output logic [osest_pkg::CNT_W-1:0]         obs_count,
  output logic [osest_pkg::STATUS_W-1:0]      status
);
  import osest_pkg::*;

  logic [DIST_W-1:0]    odom;
  logic [DIST_W-1:0]    vis;
  logic [SCALE_W-1:0]   scale_est;
  logic [SUM_W-1:0]     scale_sum;
  logic [CNT_W-1:0]     obs_counter;
  logic                 init_done;

  logic [SCALE_W-1:0]   div_rem;
  logic [DIV_W-1:0]     div_dvd;
  logic [DIV_W-1:0]     div_quot;
  logic [SCALE_W-1:0]   div_den;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [SCALE_W-1:0]          diff;
  logic [SCALE_W+FRAC_W-1:0]   prod_gate;
  logic [SCALE_W+FRAC_W:0]     prod_keep;
  logic [SCALE_W+FRAC_W-1:0]   prod_new;

  logic [SCALE_W-1:0]          scale;
  logic [SCALE_W:0]            trial;
  logic [SCALE_W:0]            trial_sub;
  logic                        trial_ge;
  logic [CNT_W-1:0]            counter_inc;
  logic [FRAC_W:0]             one_minus_alpha;
  logic [SCALE_W+FRAC_W+1:0]   ema_acc;

  // The quotient register doubles as the frame scale
  assign scale = div_quot[SCALE_W-1:0];

  always_comb begin
    trial           = {div_rem, div_dvd[DIV_W-1]};
    trial_ge        = trial >= {1'b0, div_den};
    trial_sub       = trial - {1'b0, div_den};
    counter_inc     = (obs_counter == CNT_MAX) ? obs_counter : obs_counter + CNT_W'(1);
    one_minus_alpha = {1'b1, {FRAC_W{1'b0}}} - {1'b0, cfg.ema_alpha};
    ema_acc         = {1'b0, prod_keep} + {2'b00, prod_new};

    sts.vis_small     = vis < cfg.min_visual;
    // Quotient overflows 24 bits exactly when odom >= 256 * vis
    sts.sat           = {8'h00, odom[DIST_W-1:8]} >= vis;
    sts.out_of_range  = (scale < cfg.scale_low) || (scale > cfg.scale_high);
    sts.init_done     = init_done;
    sts.count_reached = obs_counter >= cfg.init_count;
    sts.div_last      = div_cnt == DIV_CNT_W'(1);
    sts.gate_pass     = {diff, {FRAC_W{1'b0}}} < prod_gate;
  end

  // Estimator state and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_est   <= SCALE_ONE;
      scale_sum   <= '0;
      obs_counter <= '0;
      init_done   <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (cmd.accumulate) begin
        scale_sum   <= scale_sum + {{(SUM_W-SCALE_W){1'b0}}, scale};
        obs_counter <= counter_inc;
      end
      if (cmd.set_mean) begin
        scale_est <= div_quot[SCALE_W-1:0];
        init_done <= 1'b1;
      end else if (cmd.ema_apply) begin
        scale_est <= ema_acc[SCALE_W+FRAC_W-1:FRAC_W];
      end
      if (cmd.div_start_scale) begin
        div_cnt <= DIV_STEPS_SCALE;
      end else if (cmd.div_start_mean) begin
        div_cnt <= DIV_STEPS_MEAN;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
    end
  end

  // Operands, divider, products and result
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      odom <= odom_dist;
      vis  <= visual_dist;
    end
    if (cmd.load_sat) begin
      div_quot <= {{(DIV_W-SCALE_W){1'b0}}, SCALE_MAX};
    end else if (cmd.div_start_scale) begin
      div_rem  <= {8'h00, odom[DIST_W-1:8]};
      div_dvd  <= {odom[7:0], {(DIV_W-8){1'b0}}};
      div_den  <= vis;
      div_quot <= '0;
    end else if (cmd.div_start_mean) begin
      div_rem  <= '0;
      div_dvd  <= scale_sum;
      div_den  <= {{(SCALE_W-CNT_W){1'b0}}, obs_counter};
      div_quot <= '0;
    end else if (cmd.div_step) begin
      div_rem  <= trial_ge ? trial_sub[SCALE_W-1:0] : trial[SCALE_W-1:0];
      div_dvd  <= {div_dvd[DIV_W-2:0], 1'b0};
      div_quot <= {div_quot[DIV_W-2:0], trial_ge};
    end
    if (cmd.mul) begin
      diff      <= (scale > scale_est) ? scale - scale_est : scale_est - scale;
      prod_gate <= {{SCALE_W{1'b0}}, cfg.gate_fraction} * {{FRAC_W{1'b0}}, scale_est};
      prod_keep <= {{SCALE_W{1'b0}}, one_minus_alpha} * {{(FRAC_W+1){1'b0}}, scale_est};
      prod_new  <= {{SCALE_W{1'b0}}, cfg.ema_alpha} * {{FRAC_W{1'b0}}, scale};
    end
    if (cmd.out_load) begin
      scale_out      <= scale_est;
      is_initialized <= init_done;
      obs_count      <= obs_counter;
      status         <= cmd.code;
    end
  end

  `OSE_ASSERT(a_init_sticky, !$fell(init_done), "init flag dropped")
  `OSE_ASSERT(a_cnt_only_acc, !$past(rst) && !$past(cmd.accumulate) |-> $stable(obs_counter), "counter moved without accumulate")
  `OSE_ASSERT(a_est_only_cmd, !$past(rst) && !$past(cmd.set_mean) && !$past(cmd.ema_apply) |-> $stable(scale_est), "estimate moved without update")
  `OSE_ASSERT(a_rem_below_den, div_cnt != '0 |-> div_rem < div_den, "divider remainder not below divisor")

endmodule

@@ rtl/osest_ctrl.sv @@
// Sequencer of the scale estimator: walks one item through check, divide,
// range test, init or EMA update and result hand-off. Depends on osest_pkg.
`include "assert_macros.svh"

module osest_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  osest_pkg::sts_t sts,
  output osest_pkg::cmd_t cmd
);
  import osest_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_SCALE,
    S_RANGE,
    S_ACC_CHECK,
    S_DIV_MEAN,
    S_MEAN_SET,
    S_GATE_MUL,
    S_GATE_TEST,
    S_FINISH
  } state_t;

  state_t  state, state_next;
  status_t fin_status, fin_status_next;
  logic    out_valid_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    cmd             = '0;
    cmd.code        = fin_status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.vis_small) begin
          fin_status_next = ST_SMALL_VISUAL;
          state_next      = S_FINISH;
        end else if (sts.sat) begin
          cmd.load_sat = 1'b1;
          state_next   = S_RANGE;
        end else begin
          cmd.div_start_scale = 1'b1;
          state_next          = S_DIV_SCALE;
        end
      end
      S_DIV_SCALE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_RANGE;
      end
      S_RANGE: begin
        if (sts.out_of_range) begin
          fin_status_next = ST_OUT_OF_RANGE;
          state_next      = S_FINISH;
        end else if (!sts.init_done) begin
          cmd.accumulate = 1'b1;
          state_next     = S_ACC_CHECK;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_GATE_TEST;
        end
      end
      S_ACC_CHECK: begin
        if (sts.count_reached) begin
          cmd.div_start_mean = 1'b1;
          state_next         = S_DIV_MEAN;
        end else begin
          fin_status_next = ST_ACCUMULATED;
          state_next      = S_FINISH;
        end
      end
      S_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_MEAN_SET;
      end
      S_MEAN_SET: begin
        cmd.set_mean    = 1'b1;
        fin_status_next = ST_INITIALIZED;
        state_next      = S_FINISH;
      end
      S_GATE_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_GATE_TEST;
      end
      S_GATE_TEST: begin
        if (sts.gate_pass) begin
          cmd.ema_apply   = 1'b1;
          fin_status_next = ST_EMA_UPDATED;
        end else begin
          fin_status_next = ST_GATED;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Hold until the result register is free
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= ST_SMALL_VISUAL;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
      out_valid  <= out_valid_next;
    end
  end

  `OSE_ASSERT(a_accept_to_check, in_valid && !in_stall |=> state == S_CHECK, "accepted item did not start")
  `OSE_ASSERT(a_no_overwrite, cmd.out_load |-> !out_valid || !out_stall, "result overwritten while waiting")
  `OSE_ASSERT(a_one_step_kind, !(cmd.div_step && (cmd.div_start_scale || cmd.div_start_mean)), "divider start and step together")
  `OSE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && state == S_IDLE, "reset left a result pending")

endmodule

@@ rtl/odometry_scale_estimator.sv @@
// Top level of the odometry scale estimator: register file, sequencer and datapath.
// Depends on osest_pkg, osest_ctrl and osest_dp.
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ------------------------------------------
//   input    in_valid / in_stall     odom_dist, visual_dist (Q8.16)
//   output   out_valid / out_stall   scale_out, is_initialized, obs_count, status
//   config   psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// One item at a time. A frame with too small a visual motion goes from accept
// through the check straight to the result hand-off. A frame that runs the
// shared bit-serial divider gets one quotient bit per cycle from it, and the
// item that forms the initial mean reuses that divider for the mean division.
// Saturated frames skip the divider.
// rst is synchronous and active high; it restores every register default and
// the estimator state (estimate 1.0, empty sum). A stalled result stays in the
// output register, and the next item is still taken and processed; it waits
// only at the hand-off until the pending result has been taken.

module odometry_scale_estimator (
  input  logic                                clk,
  input  logic                                rst,
  // Input item
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [osest_pkg::DIST_W-1:0]        odom_dist,
  input  logic [osest_pkg::DIST_W-1:0]        visual_dist,
  // Result item
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [osest_pkg::SCALE_W-1:0]       scale_out,
  output logic                                is_initialized,
  output logic [osest_pkg::CNT_W-1:0]         obs_count,
  output logic [osest_pkg::STATUS_W-1:0]      status,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [osest_pkg::PADDR_W-1:0]       paddr,
  input  logic [osest_pkg::PDATA_W-1:0]       pwdata,
  output logic [osest_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);
  import osest_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic       reg_wr;
  logic [2:0] reg_idx;

  // Zero-wait-state port; registers sit on word addresses
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_visual    <= MIN_VISUAL_RST;
      cfg.scale_low     <= SCALE_LOW_RST;
      cfg.scale_high    <= SCALE_HIGH_RST;
      cfg.init_count    <= INIT_COUNT_RST;
      cfg.gate_fraction <= GATE_FRACTION_RST;
      cfg.ema_alpha     <= EMA_ALPHA_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_MIN_VISUAL:    cfg.min_visual    <= pwdata[DIST_W-1:0];
        REG_SCALE_LOW:     cfg.scale_low     <= pwdata[SCALE_W-1:0];
        REG_SCALE_HIGH:    cfg.scale_high    <= pwdata[SCALE_W-1:0];
        REG_INIT_COUNT:    cfg.init_count    <= pwdata[CNT_W-1:0];
        REG_GATE_FRACTION: cfg.gate_fraction <= pwdata[FRAC_W-1:0];
        REG_EMA_ALPHA:     cfg.ema_alpha     <= pwdata[FRAC_W-1:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  // Read back, zero-extended; unused addresses read zero
  always_comb begin
    case (reg_idx)
      REG_MIN_VISUAL:    prdata = {{(PDATA_W-DIST_W){1'b0}}, cfg.min_visual};
      REG_SCALE_LOW:     prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg.scale_low};
      REG_SCALE_HIGH:    prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg.scale_high};
      REG_INIT_COUNT:    prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg.init_count};
      REG_GATE_FRACTION: prdata = {{(PDATA_W-FRAC_W){1'b0}}, cfg.gate_fraction};
      REG_EMA_ALPHA:     prdata = {{(PDATA_W-FRAC_W){1'b0}}, cfg.ema_alpha};
      default:           prdata = '0;
    endcase
  end

  // Sequencer: one state per phase of an item, issues datapath commands
  osest_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: divider, products, estimator state, result register
  osest_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .odom_dist      (odom_dist),
    .visual_dist    (visual_dist),
    .scale_out      (scale_out),
    .is_initialized (is_initialized),
    .obs_count      (obs_count),
    .status         (status)
  );

endmodule

@@ tb/ose_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for odometry_scale_estimator: tracks the register port and both item
// channels, predicts each result from its own copy of the estimator and compares.
// Depends on osest_pkg.
module ose_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [osest_pkg::DIST_W-1:0]     odom_dist,
  input  logic [osest_pkg::DIST_W-1:0]     visual_dist,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [osest_pkg::SCALE_W-1:0]    scale_out,
  input  logic                             is_initialized,
  input  logic [osest_pkg::CNT_W-1:0]      obs_count,
  input  logic [osest_pkg::STATUS_W-1:0]   status,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [osest_pkg::PADDR_W-1:0]    paddr,
  input  logic [osest_pkg::PDATA_W-1:0]    pwdata,
  input  logic [osest_pkg::PDATA_W-1:0]    prdata,
  input  logic                             pready,
  output int                               fail_count,
  output int                               pending,
  output int                               results_checked,
  output int                               ema_moves,
  output logic [osest_pkg::SCALE_W-1:0]    estimate
);
  import osest_pkg::*;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               ready;
    logic [CNT_W-1:0]   count;
    status_t            code;
  } report_t;

  cfg_t               cfg;
  logic [SUM_W-1:0]   scale_sum;
  logic [CNT_W-1:0]   n_obs;
  logic [SCALE_W-1:0] est_scale;
  logic               est_ready;
  report_t            owed_reports[$];
  report_t            got;
  logic [PDATA_W-1:0] reg_now;

  // Advance the estimator by one frame and return the result it reports.
  function automatic report_t estimate_after_frame(input logic [DIST_W-1:0] odom,
                                                   input logic [DIST_W-1:0] vis);
    report_t    r;
    status_t    code;
    logic [63:0] quot;
    logic [63:0] s;
    logic [63:0] dev;
    logic [63:0] room;
    logic [63:0] acc;
    if (vis < cfg.min_visual) begin
      code = ST_SMALL_VISUAL;
    end else begin
      if (vis == '0) begin
        s = {40'h0, SCALE_MAX};
      end else begin
        quot = {24'h0, odom, 16'h0} / {40'h0, vis};
        s = (quot > {40'h0, SCALE_MAX}) ? {40'h0, SCALE_MAX} : quot;
      end
      if (s < {40'h0, cfg.scale_low} || s > {40'h0, cfg.scale_high}) begin
        code = ST_OUT_OF_RANGE;
      end else if (!est_ready) begin
        scale_sum = scale_sum + s[SUM_W-1:0];
        if (n_obs != CNT_MAX) n_obs = n_obs + CNT_W'(1);
        if (n_obs >= cfg.init_count) begin
          est_scale = SCALE_W'(scale_sum / {24'h0, n_obs});
          est_ready = 1'b1;
          code = ST_INITIALIZED;
        end else begin
          code = ST_ACCUMULATED;
        end
      end else begin
        dev = (s > {40'h0, est_scale}) ? s - {40'h0, est_scale} : {40'h0, est_scale} - s;
        room = {48'h0, cfg.gate_fraction} * {40'h0, est_scale};
        if ((dev << 16) < room) begin
          acc = (64'd65536 - {48'h0, cfg.ema_alpha}) * {40'h0, est_scale}
              + {48'h0, cfg.ema_alpha} * s;
          est_scale = acc[39:16];
          code = ST_EMA_UPDATED;
          ema_moves++;
        end else begin
          code = ST_GATED;
        end
      end
    end
    r.scale = est_scale;
    r.ready = est_ready;
    r.count = n_obs;
    r.code  = code;
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] seen);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.min_visual    = MIN_VISUAL_RST;
      cfg.scale_low     = SCALE_LOW_RST;
      cfg.scale_high    = SCALE_HIGH_RST;
      cfg.init_count    = INIT_COUNT_RST;
      cfg.gate_fraction = GATE_FRACTION_RST;
      cfg.ema_alpha     = EMA_ALPHA_RST;
      scale_sum = '0;
      n_obs = '0;
      est_scale = SCALE_ONE;
      est_ready = 1'b0;
      owed_reports.delete();
      fail_count = 0;
      results_checked = 0;
      ema_moves = 0;
      pending <= 0;
      estimate <= SCALE_ONE;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PADDR_W-1:2])
            REG_MIN_VISUAL:    cfg.min_visual    = pwdata[DIST_W-1:0];
            REG_SCALE_LOW:     cfg.scale_low     = pwdata[SCALE_W-1:0];
            REG_SCALE_HIGH:    cfg.scale_high    = pwdata[SCALE_W-1:0];
            REG_INIT_COUNT:    cfg.init_count    = pwdata[CNT_W-1:0];
            REG_GATE_FRACTION: cfg.gate_fraction = pwdata[FRAC_W-1:0];
            REG_EMA_ALPHA:     cfg.ema_alpha     = pwdata[FRAC_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[PADDR_W-1:2])
            REG_MIN_VISUAL:    reg_now = {8'h0, cfg.min_visual};
            REG_SCALE_LOW:     reg_now = {8'h0, cfg.scale_low};
            REG_SCALE_HIGH:    reg_now = {8'h0, cfg.scale_high};
            REG_INIT_COUNT:    reg_now = {24'h0, cfg.init_count};
            REG_GATE_FRACTION: reg_now = {16'h0, cfg.gate_fraction};
            REG_EMA_ALPHA:     reg_now = {16'h0, cfg.ema_alpha};
            default:           reg_now = '0;
          endcase
          if (prdata !== reg_now) flag("register readback", reg_now, prdata);
        end
      end
      if (out_valid && !out_stall) begin
        if (owed_reports.size() == 0) begin
          $display("%0t ns: result arrived with no frame waiting for it", $time);
          fail_count++;
        end else begin
          got = owed_reports.pop_front();
          results_checked++;
          if (scale_out !== got.scale)
            flag("scale_out", 32'(got.scale), 32'(scale_out));
          if (is_initialized !== got.ready)
            flag("is_initialized", 32'(got.ready), 32'(is_initialized));
          if (obs_count !== got.count)
            flag("obs_count", 32'(got.count), 32'(obs_count));
          if (status !== got.code)
            flag("status", 32'(got.code), 32'(status));
        end
      end
      if (in_valid && !in_stall)
        owed_reports.push_back(estimate_after_frame(odom_dist, visual_dist));
      pending <= owed_reports.size();
      estimate <= est_scale;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the odometry_scale_estimator testbench: clock, reset, frame stimulus,
// register writes, output stall pattern and verdict. Depends on osest_pkg and ose_checker.
module tb;
  import osest_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int PRE_INIT_FRAMES  = 200;
  localparam int FRAMES_PER_PHASE = 125;
  localparam int N_PHASES         = 8;
  localparam int END_WAIT         = 80;

  // Receiver behavior of the output stall, changed after a random stretch
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_RUNS  = 3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DIST_W-1:0]    odom_dist = '0;
  logic [DIST_W-1:0]    visual_dist = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SCALE_W-1:0]   scale_out;
  logic                 is_initialized;
  logic [CNT_W-1:0]     obs_count;
  logic [STATUS_W-1:0]  status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int                   fail_count;
  int                   pending;
  int                   results_checked;
  int                   ema_moves;
  logic [SCALE_W-1:0]   estimate;

  int                   frames_sent = 0;
  int                   settings_used = 0;
  int                   burst_left = 0;
  int                   idle_cycles = 0;
  int                   stall_mode = STALL_NONE;
  int                   mode_left = 0;
  int                   run_left = 0;
  logic [DIST_W-1:0]    cur_min_visual = MIN_VISUAL_RST;

  odometry_scale_estimator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .odom_dist(odom_dist), .visual_dist(visual_dist),
    .out_valid(out_valid), .out_stall(out_stall),
    .scale_out(scale_out), .is_initialized(is_initialized),
    .obs_count(obs_count), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ose_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .odom_dist(odom_dist), .visual_dist(visual_dist),
    .out_valid(out_valid), .out_stall(out_stall),
    .scale_out(scale_out), .is_initialized(is_initialized),
    .obs_count(obs_count), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending),
    .results_checked(results_checked), .ema_moves(ema_moves),
    .estimate(estimate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output stall: pick a behavior for a random stretch, then switch. Runs mode
  // toggles stall between high and low after each random run.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= ~out_stall;
          run_left <= $urandom_range(1, 40);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // Watchdog: any handshake or register access restarts the count.
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write one register (setup + access), then read it back so the checker
  // can compare prdata against its copy. Leaves the bus idle before returning.
  task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MIN_VISUAL) cur_min_visual = value[DIST_W-1:0];
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] min_vis, input logic [31:0] lo,
                                input logic [31:0] hi, input logic [31:0] init_n,
                                input logic [31:0] gate, input logic [31:0] alpha);
    set_register(REG_MIN_VISUAL, min_vis);
    set_register(REG_SCALE_LOW, lo);
    set_register(REG_SCALE_HIGH, hi);
    set_register(REG_INIT_COUNT, init_n);
    set_register(REG_GATE_FRACTION, gate);
    set_register(REG_EMA_ALPHA, alpha);
    settings_used++;
  endtask

  // Present one frame and hold it until accepted. Frames go out in bursts;
  // between bursts drop valid for a random gap (sometimes none at all).
  task automatic send_frame(input logic [DIST_W-1:0] odom, input logic [DIST_W-1:0] vis);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 45);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    odom_dist <= odom;
    visual_dist <= vis;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    frames_sent++;
  endtask

  // Frame whose scale is pct percent of the current estimate (visual = 1.0,
  // so the frame scale equals odom exactly).
  task automatic aimed_frame(input int unsigned pct);
    logic [63:0] want;
    want = {40'h0, estimate} * 64'(pct) / 64'd100;
    send_frame((want > 64'hFFFFFF) ? '1 : want[DIST_W-1:0], 24'h010000);
  endtask

  // Mostly plausible frames centered on the estimate, plus raw noise, frames
  // under the visual floor and field extremes.
  task automatic random_frame();
    int unsigned        pick;
    logic [31:0]        r1;
    logic [31:0]        r2;
    logic [63:0]        lo;
    logic [63:0]        center;
    logic [63:0]        prod;
    logic [DIST_W-1:0]  odom;
    logic [DIST_W-1:0]  vis;
    pick = $urandom_range(0, 99);
    r1 = $urandom;
    r2 = $urandom;
    lo = (cur_min_visual == '0) ? 64'd1 : {40'h0, cur_min_visual};
    center = (estimate == '0) ? 64'd65536 : {40'h0, estimate};
    if (pick < 70) begin
      if (lo > 64'h3FFFFF) begin
        vis = lo[DIST_W-1:0];
      end else begin
        r2 = $urandom_range(lo[31:0], 32'h3FFFFF);
        vis = r2[DIST_W-1:0];
      end
      prod = {40'h0, vis} * (center / 64'd2 + 64'($urandom_range(0, center[31:0])));
      odom = (prod[63:16] > 48'hFFFFFF) ? '1 : prod[39:16];
    end else if (pick < 85) begin
      odom = r1[DIST_W-1:0];
      vis = r2[DIST_W-1:0];
    end else if (pick < 95) begin
      odom = r1[DIST_W-1:0];
      if (cur_min_visual == '0) begin
        vis = '0;
      end else begin
        r2 = $urandom_range(0, {8'h0, cur_min_visual} - 32'd1);
        vis = r2[DIST_W-1:0];
      end
    end else begin
      odom = r1[0] ? '1 : '0;
      case (r2[1:0])
        2'd0:    vis = '0;
        2'd1:    vis = '1;
        default: vis = lo[DIST_W-1:0];
      endcase
    end
    send_frame(odom, vis);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int i;
    int p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: visual floor, saturation, range edges, plain accumulation.
    send_frame('0, '0);
    send_frame('1, 24'd65);
    send_frame('0, 24'd66);
    send_frame('1, 24'd66);
    send_frame(24'd655, 24'h010000);
    send_frame(24'd654, 24'h010000);
    send_frame(24'd6553600, 24'h010000);
    send_frame(24'd6553601, 24'h010000);
    send_frame('1, '1);

    // Open everything up: zero visual distance saturates and is accepted.
    drain();
    set_register(REG_MIN_VISUAL, 32'd0);
    set_register(REG_SCALE_LOW, 32'd0);
    set_register(REG_SCALE_HIGH, 32'hFFFFFF);
    set_register(REG_INIT_COUNT, 32'd255);
    send_frame(24'd5, '0);
    send_frame('0, 24'd1);
    send_frame('1, 24'd1);

    // Inverted range rejects every frame.
    drain();
    set_register(REG_SCALE_LOW, 32'd1000);
    set_register(REG_SCALE_HIGH, 32'd999);
    send_frame(24'd1000, 24'h010000);
    send_frame(24'd999, 24'h010000);

    // Long accumulation before the estimate is formed.
    drain();
    set_register(REG_MIN_VISUAL, 32'(MIN_VISUAL_RST));
    set_register(REG_SCALE_LOW, 32'(SCALE_LOW_RST));
    set_register(REG_SCALE_HIGH, 32'(SCALE_HIGH_RST));
    for (i = 0; i < PRE_INIT_FRAMES; i++) random_frame();

    // Init count zero: the next accepted frame forms the mean.
    drain();
    set_register(REG_INIT_COUNT, 32'd0);
    send_frame(24'h020000, 24'h010000);

    // Gate closed: even an exact match is an outlier.
    drain();
    set_register(REG_GATE_FRACTION, 32'd0);
    aimed_frame(100);

    // Widest gate, zero weight: update reported but estimate holds.
    drain();
    set_register(REG_GATE_FRACTION, 32'd65535);
    set_register(REG_EMA_ALPHA, 32'd0);
    aimed_frame(125);

    // Full weight: estimate jumps almost to the new scale.
    drain();
    set_register(REG_EMA_ALPHA, 32'd65535);
    aimed_frame(125);

    // Default gate and weight: small step passes, large one is gated.
    drain();
    set_register(REG_GATE_FRACTION, 32'(GATE_FRACTION_RST));
    set_register(REG_EMA_ALPHA, 32'(EMA_ALPHA_RST));
    aimed_frame(110);
    aimed_frame(300);

    // Tracking phases over a spread of settings, extremes included.
    for (p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: apply_settings(32'(MIN_VISUAL_RST), 32'(SCALE_LOW_RST), 32'(SCALE_HIGH_RST),
                          32'(INIT_COUNT_RST), 32'(GATE_FRACTION_RST),
                          32'(EMA_ALPHA_RST));
        1: apply_settings(32'd0, 32'd0, 32'hFFFFFF, 32'd255, 32'd65535, 32'd65535);
        3: apply_settings(32'hFFFFFF, 32'd655, 32'hFFFFFF, 32'd1, 32'd0, 32'd0);
        5: apply_settings(32'd0, 32'd0, 32'hFFFFFF, 32'd0, 32'd65535, 32'd0);
        default: apply_settings($urandom_range(0, 4096), $urandom_range(0, 65536),
                                $urandom_range(131072, 32'hFFFFFF), $urandom_range(1, 255),
                                $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      for (i = 0; i < FRAMES_PER_PHASE; i++) random_frame();
    end

    // Let the last results out, then allow the pipeline to settle.
    drain();
    repeat (END_WAIT) @(posedge clk);

    $display("Run covered %0d frames under %0d full register settings plus directed writes.",
             frames_sent, settings_used);
    $display("Results checked: %0d, of which %0d moved the estimate by EMA.",
             results_checked, ema_moves);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
